// ===== hw/rtl/weekly_profile_residual_coder_defines.svh =====
// ----------------------------------------------------------------------------
// Weekly profile residual coder: assertion macros
// Shared assertion helpers; defining NO_ASSERTIONS turns every check off.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_PROFILE_RESIDUAL_CODER_DEFINES_SVH
`define WEEKLY_PROFILE_RESIDUAL_CODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define WPRC_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("wprc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WPRC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("wprc assertion failed");

`else

`define WPRC_ASSERT_NOW(label, clk, rst, cond, expr)
`define WPRC_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== hw/rtl/wprc_pkg.sv =====
// ----------------------------------------------------------------------------
// Weekly profile residual coder: package
// Default sizes, register widths, reset values and operation codes.
// ----------------------------------------------------------------------------
package wprc_pkg;

   // Default sizes: one slot per quarter hour of a week.
   localparam int SLOTS_DEFAULT      = 7 * 24 * 4;
   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int SUM_BITS_DEFAULT   = 40;

   // Register widths and the width of the combined divisor.
   localparam int WEEKS_BITS   = 7;
   localparam int SENSORS_BITS = 9;
   localparam int SPS_BITS     = 20;
   localparam int DIV_BITS     = WEEKS_BITS + SENSORS_BITS;

   // Register reset values.
   localparam logic [WEEKS_BITS-1:0]   WEEKS_RESET   = WEEKS_BITS'(52);
   localparam logic [SENSORS_BITS-1:0] SENSORS_RESET = SENSORS_BITS'(1);
   localparam logic [SPS_BITS-1:0]     SPS_RESET     = SPS_BITS'(35040);

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Operation codes carried in req_tuser.
   localparam int OP_BITS = 2;
   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR  = 2'd0,
      OP_ACCUM  = 2'd1,
      OP_ENCODE = 2'd2
   } op_type;

   // Register indexes (word addresses).
   typedef enum logic [1:0] {
      CSR_WEEKS   = 2'd0,
      CSR_SENSORS = 2'd1,
      CSR_SAMPLES = 2'd2
   } csr_reg_type;

endpackage

// ===== hw/rtl/weekly_profile_residual_coder.sv =====
// ----------------------------------------------------------------------------
// Weekly profile residual coder
// Accumulates samples into per-slot weekly sums, then codes each sample as
// the zigzag residual against the floored slot average.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// req_*     in         tuser: operation; tdata: sample_value
// rsp_*     out        tdata: reference, zigzag residual, minimum, maximum
// csr_*     in/out     APB-style registers: weeks, sensors, samples/series
//
// Encode runs a restoring divider that retires one quotient bit per cycle.
// Clear sweeps the slot store at one entry per cycle. After reset the same
// sweep runs before the first item is taken. One item is in flight at a time;
// a result waiting on rsp_tready holds the block in its result state.
// ----------------------------------------------------------------------------
`include "weekly_profile_residual_coder_defines.svh"

module weekly_profile_residual_coder
   import wprc_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int SUM_BITS   = SUM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   // Input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [VALUE_BITS-1:0] sample_value, zero padded to bytes
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,
   // tuser: [1:0] operation
   input  logic [OP_BITS-1:0]                  req_tuser,

   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata from bit 0 up: reference_value, zigzag_residual (VALUE_BITS+1),
   // min_seen, max_seen, zero padded to bytes
   output logic [((4*VALUE_BITS+8)/8)*8-1:0]   rsp_tdata,

   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]            csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]            csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]            csr_prdata,
   output logic                                csr_pready
);

   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(SUM_BITS);
   localparam int ADD_BITS  = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
   localparam int QUOT_BITS = (SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS;
   localparam int RSP_BITS  = 4 * VALUE_BITS + 1;
   localparam int RSP_W     = ((4 * VALUE_BITS + 8) / 8) * 8;

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACC,
      S_LOAD,
      S_DIV,
      S_RESULT
   } state_type;

   // Registers
   state_type                 state_ff;
   logic [SLOT_BITS-1:0]      clr_addr_ff;
   logic                      clr_reply_ff;
   op_type                    op_ff;
   logic [VALUE_BITS-1:0]     sample_ff;
   logic [SPS_BITS-1:0]       sample_index_ff;
   logic [SLOT_BITS-1:0]      slot_index_ff;
   logic [VALUE_BITS-1:0]     min_ff;
   logic [VALUE_BITS-1:0]     max_ff;
   logic [SUM_BITS-1:0]       num_ff;
   logic [DIV_BITS-1:0]       rem_ff;
   logic [CNT_BITS-1:0]       cnt_ff;
   logic [DIV_BITS-1:0]       divisor_ff;
   logic [SUM_BITS-1:0]       rd_data_ff;
   logic                      rsp_tvalid_ff;
   logic [RSP_BITS-1:0]       rsp_data_ff;
   logic [WEEKS_BITS-1:0]     weeks_ff;
   logic [SENSORS_BITS-1:0]   sensors_ff;
   logic [SPS_BITS-1:0]       sps_ff;

   // Slot store
   logic [SUM_BITS-1:0]       slot_mem [SLOTS];

   // Combinational values
   logic                      req_fire;
   logic                      rsp_free;
   logic                      csr_write;
   logic [WEEKS_BITS-1:0]     weeks_eff;
   logic [SENSORS_BITS-1:0]   sensors_eff;
   logic [DIV_BITS-1:0]       divisor_in;
   logic [ADD_BITS-1:0]       add_full;
   logic [SUM_BITS-1:0]       sum_in;
   logic [DIV_BITS:0]         trial;
   logic [DIV_BITS:0]         diff;
   logic                      qbit;
   logic [DIV_BITS-1:0]       rem_in;
   logic [QUOT_BITS-1:0]      quot_ext;
   logic [VALUE_BITS-1:0]     ref_in;
   logic [VALUE_BITS:0]       resid;
   logic [VALUE_BITS:0]       zig_in;
   logic [SPS_BITS:0]         next_index;
   logic [SPS_BITS-1:0]       limit;
   logic                      mem_we;
   logic [SLOT_BITS-1:0]      mem_waddr;
   logic [SUM_BITS-1:0]       mem_wdata;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Configuration registers, written during the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         weeks_ff   <= WEEKS_RESET;
         sensors_ff <= SENSORS_RESET;
         sps_ff     <= SPS_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[CSR_ADDR_BITS-1:2])
            CSR_WEEKS:   weeks_ff   <= csr_pwdata[WEEKS_BITS-1:0];
            CSR_SENSORS: sensors_ff <= csr_pwdata[SENSORS_BITS-1:0];
            CSR_SAMPLES: sps_ff     <= csr_pwdata[SPS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_paddr[CSR_ADDR_BITS-1:2])
         CSR_WEEKS:   csr_prdata = CSR_DATA_BITS'(weeks_ff);
         CSR_SENSORS: csr_prdata = CSR_DATA_BITS'(sensors_ff);
         CSR_SAMPLES: csr_prdata = CSR_DATA_BITS'(sps_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // Combined divisor; a zero factor counts as one.
   assign weeks_eff   = (weeks_ff == '0) ? WEEKS_BITS'(1) : weeks_ff;
   assign sensors_eff = (sensors_ff == '0) ? SENSORS_BITS'(1) : sensors_ff;
   assign divisor_in  = DIV_BITS'(DIV_BITS'(weeks_eff) * DIV_BITS'(sensors_eff));

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
   end

   // Saturating add of the sample into its slot sum.
   always_comb begin
      add_full = ADD_BITS'(rd_data_ff) + ADD_BITS'(sample_ff);
      if (add_full > ADD_BITS'(SUM_MAX)) begin
         sum_in = SUM_MAX;
      end else begin
         sum_in = add_full[SUM_BITS-1:0];
      end
   end

   // One restoring division step: trial subtract of the divisor.
   always_comb begin
      trial = {rem_ff, num_ff[SUM_BITS-1]};
      diff  = trial - {1'b0, divisor_ff};
      qbit  = !diff[DIV_BITS];
      if (qbit) begin
         rem_in = diff[DIV_BITS-1:0];
      end else begin
         rem_in = trial[DIV_BITS-1:0];
      end
   end

   // Reference saturates to the value range; zigzag of reference minus sample.
   always_comb begin
      quot_ext = QUOT_BITS'(num_ff);
      if (quot_ext > QUOT_BITS'(VALUE_MAX)) begin
         ref_in = VALUE_MAX;
      end else begin
         ref_in = quot_ext[VALUE_BITS-1:0];
      end
      resid  = {1'b0, ref_in} - {1'b0, sample_ff};
      zig_in = {resid[VALUE_BITS-1:0], 1'b0} ^ {(VALUE_BITS+1){resid[VALUE_BITS]}};
   end

   // Series position; a zero series length counts as one.
   assign next_index = {1'b0, sample_index_ff} + (SPS_BITS+1)'(1);
   assign limit      = (sps_ff == '0) ? SPS_BITS'(1) : sps_ff;

   // Slot store write port: clearing sweep or accumulate write-back.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_index_ff;
      mem_wdata = sum_in;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (state_ff == S_ACC) begin
         mem_we = 1'b1;
      end
   end

   // Slot store with a registered read of the current slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[slot_index_ff];
   end

   // Sequencer with datapath and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_addr_ff     <= '0;
         clr_reply_ff    <= 1'b0;
         sample_index_ff <= '0;
         slot_index_ff   <= '0;
         min_ff          <= '1;
         max_ff          <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         // The result register empties on its transfer, unless the result
         // state loads it again in the same cycle.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_RESULT)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               if (clr_addr_ff == SLOT_BITS'(SLOTS - 1)) begin
                  clr_addr_ff <= '0;
                  state_ff    <= clr_reply_ff ? S_RESULT : S_IDLE;
               end else begin
                  clr_addr_ff <= clr_addr_ff + SLOT_BITS'(1);
               end
            end

            S_IDLE: begin
               if (req_fire) begin
                  op_ff     <= op_type'(req_tuser);
                  sample_ff <= req_tdata[VALUE_BITS-1:0];
                  unique case (req_tuser)
                     OP_CLEAR: begin
                        clr_addr_ff     <= '0;
                        clr_reply_ff    <= 1'b1;
                        sample_index_ff <= '0;
                        slot_index_ff   <= '0;
                        state_ff        <= S_CLEAR;
                     end
                     OP_ACCUM:  state_ff <= S_ACC;
                     OP_ENCODE: state_ff <= S_LOAD;
                     default:   state_ff <= S_RESULT;
                  endcase
               end
            end

            S_ACC: begin
               // The sum write-back goes through the store's write port.
               if (sample_ff < min_ff) begin
                  min_ff <= sample_ff;
               end
               if (sample_ff > max_ff) begin
                  max_ff <= sample_ff;
               end
               state_ff <= S_RESULT;
            end

            S_LOAD: begin
               num_ff   <= rd_data_ff;
               rem_ff   <= '0;
               cnt_ff   <= CNT_BITS'(SUM_BITS - 1);
               state_ff <= S_DIV;
            end

            S_DIV: begin
               rem_ff <= rem_in;
               num_ff <= {num_ff[SUM_BITS-2:0], qbit};
               if (cnt_ff == '0) begin
                  state_ff <= S_RESULT;
               end else begin
                  cnt_ff <= cnt_ff - CNT_BITS'(1);
               end
            end

            S_RESULT: begin
               if (rsp_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  clr_reply_ff  <= 1'b0;
                  if (op_ff == OP_ENCODE) begin
                     rsp_data_ff <= {max_ff, min_ff, zig_in, ref_in};
                  end else begin
                     rsp_data_ff <= {max_ff, min_ff, {(VALUE_BITS+1){1'b0}},
                                     {VALUE_BITS{1'b0}}};
                  end
                  // Accumulate and encode move to the next sample position.
                  if ((op_ff == OP_ACCUM) || (op_ff == OP_ENCODE)) begin
                     if (next_index >= {1'b0, limit}) begin
                        sample_index_ff <= '0;
                        slot_index_ff   <= '0;
                     end else begin
                        sample_index_ff <= next_index[SPS_BITS-1:0];
                        if (slot_index_ff == SLOT_BITS'(SLOTS - 1)) begin
                           slot_index_ff <= '0;
                        end else begin
                           slot_index_ff <= slot_index_ff + SLOT_BITS'(1);
                        end
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The slot index never leaves the store.
   `WPRC_ASSERT_NOW(a_slot_in_range, clock, reset, 1'b1, slot_index_ff <= SLOT_BITS'(SLOTS - 1))

   // The partial remainder stays below the divisor throughout the division.
   `WPRC_ASSERT_NOW(a_rem_below_div, clock, reset, state_ff == S_DIV, rem_ff < divisor_ff)

   // An accepted encode goes straight to loading the divider.
   `WPRC_ASSERT_NEXT(a_encode_loads, clock, reset, req_fire && (req_tuser == OP_ENCODE), state_ff == S_LOAD)

endmodule
